FILE: rtl/core/dpfa_pkg.sv
// ----------------------------------------------------------------------------
// dpfa_pkg
// Shared widths, codes and reset values of the dual pool page frame allocator.
// ----------------------------------------------------------------------------
package dpfa_pkg;

  localparam int ADDR_W     = 40;
  localparam int FREE_W     = 13;
  localparam int BASE_W     = 28;
  localparam int KCNT_W     = 11;
  localparam int UCNT_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;
  // wide enough for a stack depth plus a never-used count at the largest depth
  localparam int CNT_W      = 22;

  localparam logic [FREE_W-1:0] FREE_SAT = '1;

  localparam int DEF_PAGE_SHIFT   = 12;
  localparam int DEF_KERNEL_DEPTH = 1024;
  localparam int DEF_USER_DEPTH   = 4096;
  localparam int DEF_ADDRESS_BITS = 40;

  localparam logic [BASE_W-1:0] RST_KBASE = 28'd524288;
  localparam logic [KCNT_W-1:0] RST_KCNT  = 11'd1024;
  localparam logic [UCNT_W-1:0] RST_UCNT  = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_KBASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KCNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UCNT  = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

FILE: rtl/core/dpfa_stack_ram.sv
// ----------------------------------------------------------------------------
// dpfa_stack_ram
// One write port, one read port memory with registered read data.
// ----------------------------------------------------------------------------
module dpfa_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/dual_pool_page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// dual_pool_page_frame_allocator_unit
// Kernel and user page pools, each a LIFO of freed pages backed by a memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: allocate or free,
//   the pool, and for a free the page byte address. Result channel
//   (out_valid / out_stall) returns status, allocated address and the free
//   page count of that pool, one result per request, in order.
//   Configuration writes (cfg_valid / cfg_ready, always ready) set the kernel
//   base page and both page counts; write them only while no request is open.
// Request flow:
//   A request is taken only while no request is in flight. The stack top is
//   read from memory in the cycle of the transfer and registered; then the
//   pop, push and counter update complete and the result is registered onto
//   out_valid. The next request is taken only once that result is written.
// Stall:
//   The result sits in an output register. While that register is full and
//   stalled, the request in flight waits and in_stall stays high.
// Reset:
//   Clears stack depths, never-used counters and valid flags and loads the
//   register defaults. Stack memories need no clearing: an entry is used
//   only after it has been pushed.
// ----------------------------------------------------------------------------
module dual_pool_page_frame_allocator_unit import dpfa_pkg::*; #(
  parameter int PAGE_SHIFT   = DEF_PAGE_SHIFT,
  parameter int KERNEL_DEPTH = DEF_KERNEL_DEPTH,
  parameter int USER_DEPTH   = DEF_USER_DEPTH,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic                  in_pool_select,
  input  logic [ADDR_W-1:0]     in_free_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [ADDR_W-1:0]     out_page_address,
  output logic [FREE_W-1:0]     out_free_pages,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KAW  = (KERNEL_DEPTH > 1) ? $clog2(KERNEL_DEPTH) : 1;
  localparam int UAW  = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
  localparam int KSW  = $clog2(KERNEL_DEPTH + 1);
  localparam int USW  = $clog2(USER_DEPTH + 1);
  localparam int PB_W = BASE_W + 1;
  localparam int PN_W = ADDR_W + 1;
  localparam logic [63:0]       ADDR_MASK = {64{1'b1}} >> (64 - ADDRESS_BITS);
  localparam logic [ADDR_W-1:0] LOW_MASK  = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

  // configuration
  logic [BASE_W-1:0] kbase_r;
  logic [KCNT_W-1:0] kcnt_r;
  logic [UCNT_W-1:0] ucnt_r;

  // pool state
  logic [KSW-1:0] ksp_r, kfresh_r;
  logic [USW-1:0] usp_r, ufresh_r;

  // request in flight
  logic              exec_r;
  logic              func_r;
  logic              kern_r;
  logic [ADDR_W-1:0] addr_r;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [FREE_W-1:0] out_free_r;

  logic in_accept, exec_fire;
  logic [KSW-1:0] ksp_m1;
  logic [USW-1:0] usp_m1;

  logic           k_wr_en, u_wr_en;
  logic [KAW-1:0] k_rd_data;
  logic [UAW-1:0] u_rd_data;

  logic [CNT_W-1:0]  sp, fresh, cnt, dmax, off, fresh_left;
  logic [CNT_W-1:0]  sp_n, fresh_n, fl_n, sum_n, off_w;
  logic [PB_W-1:0]   base;
  logic [PB_W:0]     pn_alloc;
  logic [PN_W-1:0]   pn_free, lim;
  logic [63:0]       page64, page_m;
  logic              low_nz, wr;
  status_t           status;
  logic [FREE_W-1:0] free_sat;

  assign in_stall  = exec_r;
  assign in_accept = in_valid && !in_stall;
  assign exec_fire = exec_r && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  assign ksp_m1 = ksp_r - KSW'(1);
  assign usp_m1 = usp_r - USW'(1);

  dpfa_stack_ram #(
    .DEPTH (KERNEL_DEPTH),
    .AW    (KAW),
    .DW    (KAW)
  ) u_kstack (
    .clk     (clk),
    .wr_en   (k_wr_en),
    .wr_addr (ksp_r[KAW-1:0]),
    .wr_data (off_w[KAW-1:0]),
    .rd_en   (in_accept && in_pool_select),
    .rd_addr (ksp_m1[KAW-1:0]),
    .rd_data (k_rd_data)
  );

  dpfa_stack_ram #(
    .DEPTH (USER_DEPTH),
    .AW    (UAW),
    .DW    (UAW)
  ) u_ustack (
    .clk     (clk),
    .wr_en   (u_wr_en),
    .wr_addr (usp_r[UAW-1:0]),
    .wr_data (off_w[UAW-1:0]),
    .rd_en   (in_accept && !in_pool_select),
    .rd_addr (usp_m1[UAW-1:0]),
    .rd_data (u_rd_data)
  );

  // pick the selected pool
  always_comb begin
    if (kern_r) begin
      sp    = CNT_W'(ksp_r);
      fresh = CNT_W'(kfresh_r);
      dmax  = CNT_W'(KERNEL_DEPTH);
      cnt   = (CNT_W'(kcnt_r) > dmax) ? dmax : CNT_W'(kcnt_r);
      base  = PB_W'(kbase_r);
      off   = CNT_W'(k_rd_data);
    end else begin
      sp    = CNT_W'(usp_r);
      fresh = CNT_W'(ufresh_r);
      dmax  = CNT_W'(USER_DEPTH);
      cnt   = (CNT_W'(ucnt_r) > dmax) ? dmax : CNT_W'(ucnt_r);
      base  = PB_W'(kbase_r) + PB_W'(kcnt_r);
      off   = CNT_W'(u_rd_data);
    end
  end

  // pop, hand out a never-used page, or check and push
  always_comb begin
    fresh_left = (fresh < cnt) ? (cnt - fresh) : '0;
    status     = ST_OK;
    page64     = '0;
    pn_alloc   = '0;
    sp_n       = sp;
    fresh_n    = fresh;
    wr         = 1'b0;
    pn_free    = PN_W'(addr_r >> PAGE_SHIFT);
    low_nz     = |(addr_r & LOW_MASK);
    lim        = PN_W'(base) + PN_W'(cnt);
    off_w      = CNT_W'(pn_free - PN_W'(base));
    if (func_r == FUNC_ALLOC) begin
      if (sp != '0) begin
        sp_n     = sp - CNT_W'(1);
        pn_alloc = (PB_W + 1)'(base) + (PB_W + 1)'(off);
        page64   = 64'(pn_alloc) << PAGE_SHIFT;
      end else if (fresh_left != '0) begin
        fresh_n  = fresh + CNT_W'(1);
        pn_alloc = (PB_W + 1)'(base) + (PB_W + 1)'(fresh);
        page64   = 64'(pn_alloc) << PAGE_SHIFT;
      end else begin
        status = ST_OOM;
      end
    end else begin
      if (low_nz || pn_free < PN_W'(base) || pn_free >= lim) begin
        status = ST_BAD_ADDR;
      end else if ((sp + fresh_left >= cnt) || (sp >= dmax)) begin
        status = ST_FULL;
      end else begin
        wr   = 1'b1;
        sp_n = sp + CNT_W'(1);
      end
    end
    fl_n     = (fresh_n < cnt) ? (cnt - fresh_n) : '0;
    sum_n    = sp_n + fl_n;
    free_sat = (sum_n > CNT_W'(FREE_SAT)) ? FREE_SAT : sum_n[FREE_W-1:0];
    page_m   = page64 & ADDR_MASK;
  end

  assign k_wr_en = exec_fire && wr && kern_r;
  assign u_wr_en = exec_fire && wr && !kern_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r     <= RST_KBASE;
      kcnt_r      <= RST_KCNT;
      ucnt_r      <= RST_UCNT;
      ksp_r       <= '0;
      kfresh_r    <= '0;
      usp_r       <= '0;
      ufresh_r    <= '0;
      exec_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_KBASE: kbase_r <= cfg_data[BASE_W-1:0];
          CFG_KCNT:  kcnt_r  <= cfg_data[KCNT_W-1:0];
          CFG_UCNT:  ucnt_r  <= cfg_data[UCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        exec_r <= 1'b1;
      end else if (exec_fire) begin
        exec_r <= 1'b0;
      end
      if (exec_fire) begin
        if (kern_r) begin
          ksp_r    <= sp_n[KSW-1:0];
          kfresh_r <= fresh_n[KSW-1:0];
        end else begin
          usp_r    <= sp_n[USW-1:0];
          ufresh_r <= fresh_n[USW-1:0];
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= in_func;
      kern_r <= in_pool_select;
      addr_r <= in_free_address;
    end
    if (exec_fire) begin
      out_status_r <= status;
      out_addr_r   <= page_m[ADDR_W-1:0];
      out_free_r   <= free_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_addr_r;
  assign out_free_pages   = out_free_r;

endmodule
